[sv/mtst_pkg.sv]
// ----------------------------------------------------------------------------
// mtst_pkg
// Shared widths, event codes and sizes for the multitouch slot tracker.
// ----------------------------------------------------------------------------
package mtst_pkg;

    localparam int NUM_SLOTS   = 10;
    localparam int REPORT_SLOT = 0;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int RPT_IDX     = (REPORT_SLOT < NUM_SLOTS) ? REPORT_SLOT : NUM_SLOTS - 1;

    localparam logic [4:0] TYPE_KEY   = 5'd1;
    localparam logic [4:0] TYPE_ABS   = 5'd3;
    localparam logic [9:0] CODE_ABS_X = 10'd0;
    localparam logic [9:0] CODE_ABS_Y = 10'd1;
    localparam logic [9:0] CODE_SLOT  = 10'd47;
    localparam logic [9:0] CODE_POS_X = 10'd53;
    localparam logic [9:0] CODE_POS_Y = 10'd54;
    localparam logic [9:0] CODE_TRACK = 10'd57;
    localparam logic [9:0] CODE_TOUCH = 10'd330;

    localparam logic OP_EVENT  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [2:0] CFG_IN_X_LO  = 3'd0;
    localparam logic [2:0] CFG_IN_X_HI  = 3'd1;
    localparam logic [2:0] CFG_IN_Y_LO  = 3'd2;
    localparam logic [2:0] CFG_IN_Y_HI  = 3'd3;
    localparam logic [2:0] CFG_OUT_X_LO = 3'd4;
    localparam logic [2:0] CFG_OUT_X_HI = 3'd5;
    localparam logic [2:0] CFG_OUT_Y_LO = 3'd6;
    localparam logic [2:0] CFG_OUT_Y_HI = 3'd7;

    typedef logic [SLOT_W-1:0] slot_t;

endpackage

[sv/multitouch_event_slot_tracker.sv]
// ----------------------------------------------------------------------------
// multitouch_event_slot_tracker
// Parses touch events into a contact table held in memories and reports
// one calibrated point per report request.
// ----------------------------------------------------------------------------
// an event is handled in the decode state; a legacy axis event adds a slot 0
// write and a tracking-id search walks every owner entry; a pressed report runs
// set-up, multiply, sign and the divider for x, then for y, a released one skips them;
// the result strobe rises in the same cycle that busy drops
// one item at a time; the result strobe lasts one cycle, receiver cannot stall
// reset clears control state and valid bits at once; no clearing pass
module multitouch_event_slot_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        opcode,
    input  logic [4:0]  event_type,
    input  logic [9:0]  event_code,
    input  logic [31:0] event_value,
    output logic        done,
    output logic        touch_pressed,
    output logic [11:0] point_x,
    output logic [11:0] point_y
);

    localparam int NS = mtst_pkg::NUM_SLOTS;
    localparam int SW = mtst_pkg::SLOT_W;
    localparam int DW = 47;   // quotient / numerator width

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_SRCH  = 4'd2;
    localparam logic [3:0] ST_SWAIT = 4'd3;
    localparam logic [3:0] ST_RDRPT = 4'd4;
    localparam logic [3:0] ST_AXIS  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // configuration
    logic signed [15:0] in_x_low_reg, in_x_high_reg, in_y_low_reg, in_y_high_reg;
    logic [11:0] out_x_low_reg, out_x_high_reg, out_y_low_reg, out_y_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_x_low_reg   <= 16'sd0;
            in_x_high_reg  <= 16'sd480;
            in_y_low_reg   <= 16'sd0;
            in_y_high_reg  <= 16'sd480;
            out_x_low_reg  <= 12'd0;
            out_x_high_reg <= 12'd479;
            out_y_low_reg  <= 12'd0;
            out_y_high_reg <= 12'd479;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mtst_pkg::CFG_IN_X_LO:  in_x_low_reg   <= cfg_data;
                mtst_pkg::CFG_IN_X_HI:  in_x_high_reg  <= cfg_data;
                mtst_pkg::CFG_IN_Y_LO:  in_y_low_reg   <= cfg_data;
                mtst_pkg::CFG_IN_Y_HI:  in_y_high_reg  <= cfg_data;
                mtst_pkg::CFG_OUT_X_LO: out_x_low_reg  <= cfg_data[11:0];
                mtst_pkg::CFG_OUT_X_HI: out_x_high_reg <= cfg_data[11:0];
                mtst_pkg::CFG_OUT_Y_LO: out_y_low_reg  <= cfg_data[11:0];
                default:                out_y_high_reg <= cfg_data[11:0];
            endcase
        end
    end

    // memories: position (x,y) and owner id; valid bits give reset values
    logic [63:0] pos_mem [NS];
    logic [31:0] own_mem [NS];
    logic [NS-1:0] pos_vld_reg, own_vld_reg, down_reg;

    logic        pos_we, own_we;
    mtst_pkg::slot_t pos_waddr, own_waddr, pos_raddr, own_raddr;
    logic [63:0] pos_wdata, pos_rdata_reg;
    logic [31:0] own_wdata, own_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        if (own_we)
            own_mem[own_waddr] <= own_wdata;
        pos_rdata_reg <= pos_mem[pos_raddr];
        own_rdata_reg <= own_mem[own_raddr];
    end

    // registered copies of the read address to pick the valid bit
    mtst_pkg::slot_t pos_ra_reg, own_ra_reg;
    logic [63:0] pos_rd;
    logic [31:0] own_rd;
    assign pos_rd = pos_vld_reg[pos_ra_reg] ? pos_rdata_reg : 64'd0;
    assign own_rd = own_vld_reg[own_ra_reg] ? own_rdata_reg : 32'hFFFF_FFFF;

    // control
    logic [3:0]  state_reg, state_next;
    logic        op_reg;
    logic [4:0]  type_reg;
    logic [9:0]  code_reg;
    logic [31:0] val_reg;
    mtst_pkg::slot_t cur_reg, cur_next;
    logic        mode_reg, mode_next;
    mtst_pkg::slot_t idx_reg, idx_next;
    logic        hit_reg, hit_next, fre_reg, fre_next;
    mtst_pkg::slot_t hit_idx_reg, hit_idx_next, fre_idx_reg, fre_idx_next;
    logic [NS-1:0] down_next, pos_vld_next, own_vld_next;
    logic [11:0] held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic        axis_reg, axis_next;
    logic        pressed_reg, pressed_next;
    logic [63:0] pos_hold_reg, pos_hold_next;
    logic signed [32:0] diff_reg, diff_next;
    logic [12:0] span_o_reg, span_o_next;
    logic signed [46:0] prod_reg, prod_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [16:0]   den_reg, den_next;
    logic [5:0]    bit_reg, bit_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;

    // current axis operands
    logic signed [15:0] ilo, ihi;
    logic [11:0] olo, ohi;
    logic signed [31:0] raw;
    always_comb
    begin
        ilo = axis_reg ? in_y_low_reg : in_x_low_reg;
        ihi = axis_reg ? in_y_high_reg : in_x_high_reg;
        olo = axis_reg ? out_y_low_reg : out_x_low_reg;
        ohi = axis_reg ? out_y_high_reg : out_x_high_reg;
        raw = axis_reg ? pos_hold_reg[63:32] : pos_hold_reg[31:0];
    end

    logic signed [48:0] res_w;
    logic [11:0] clamp_v;
    logic [DW:0] rem_sh;
    always_comb
    begin
        if (ihi > ilo)
            res_w = (neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg}))
                    + $signed({37'd0, olo});
        else
            res_w = 49'(raw);
        // raise to the low end first, then lower to the high end
        if (res_w > $signed({37'd0, ohi}) ||
            (res_w < $signed({37'd0, olo}) && olo > ohi))
            clamp_v = ohi;
        else if (res_w < $signed({37'd0, olo}))
            clamp_v = olo;
        else
            clamp_v = res_w[11:0];
        rem_sh = {rem_reg[DW-1:0], quo_reg[DW-1]};
    end

    logic signed [31:0] sval;
    assign sval = val_reg;

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        mode_next    = mode_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        fre_next     = fre_reg;
        hit_idx_next = hit_idx_reg;
        fre_idx_next = fre_idx_reg;
        down_next    = down_reg;
        pos_vld_next = pos_vld_reg;
        own_vld_next = own_vld_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        axis_next    = axis_reg;
        pressed_next = pressed_reg;
        pos_hold_next = pos_hold_reg;
        diff_next    = diff_reg;
        span_o_next  = span_o_reg;
        prod_next    = prod_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        bit_next     = bit_reg;
        neg_next     = neg_reg;
        done_next    = 1'b0;
        pos_we       = 1'b0;
        own_we       = 1'b0;
        pos_waddr    = cur_reg;
        own_waddr    = idx_reg;
        pos_wdata    = pos_rd;
        own_wdata    = val_reg;
        pos_raddr    = cur_reg;
        own_raddr    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_DEC;
            end
            ST_DEC:
            begin
                // pos_rd holds the current slot (read issued at accept)
                state_next = ST_IDLE;
                if (op_reg == mtst_pkg::OP_REPORT)
                begin
                    pos_raddr  = mtst_pkg::slot_t'(mtst_pkg::RPT_IDX);
                    state_next = ST_RDRPT;
                end
                else if (type_reg == mtst_pkg::TYPE_ABS)
                begin
                    if (code_reg == mtst_pkg::CODE_SLOT)
                    begin
                        mode_next = 1'b1;
                        if (!sval[31] && sval < NS)
                            cur_next = mtst_pkg::slot_t'(val_reg);
                        else
                            cur_next = mtst_pkg::slot_t'(NS - 1);
                    end
                    else if (code_reg == mtst_pkg::CODE_TRACK)
                    begin
                        if (sval[31])
                            down_next[cur_reg] = 1'b0;
                        else if (mode_reg)
                            down_next[cur_reg] = 1'b1;
                        else
                        begin
                            idx_next   = '0;
                            hit_next   = 1'b0;
                            fre_next   = 1'b0;
                            own_raddr  = '0;
                            state_next = ST_SWAIT;
                        end
                    end
                    else if (code_reg == mtst_pkg::CODE_POS_X ||
                             code_reg == mtst_pkg::CODE_POS_Y)
                    begin
                        pos_we = 1'b1;
                        pos_vld_next[cur_reg] = 1'b1;
                        if (code_reg == mtst_pkg::CODE_POS_X)
                            pos_wdata = {pos_rd[63:32], val_reg};
                        else
                            pos_wdata = {val_reg, pos_rd[31:0]};
                    end
                    else if (code_reg == mtst_pkg::CODE_ABS_X ||
                             code_reg == mtst_pkg::CODE_ABS_Y)
                    begin
                        // slot 0 needs its own read first
                        pos_raddr = '0;
                        state_next = ST_SRCH;
                        idx_next = '0;
                        hit_next = 1'b1;
                    end
                end
                else if (type_reg == mtst_pkg::TYPE_KEY && code_reg == mtst_pkg::CODE_TOUCH)
                    down_next[0] = (val_reg != 32'd0);
            end
            ST_SRCH:
            begin
                // legacy slot 0 write, read of slot 0 now available
                pos_we    = 1'b1;
                pos_waddr = '0;
                pos_vld_next[0] = 1'b1;
                if (code_reg == mtst_pkg::CODE_ABS_X)
                    pos_wdata = {pos_rd[63:32], val_reg};
                else
                    pos_wdata = {val_reg, pos_rd[31:0]};
                state_next = ST_IDLE;
            end
            ST_SWAIT:
            begin
                // one owner entry per cycle, read issued the cycle before
                if (!hit_reg && own_rd == val_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                end
                if (!fre_reg && own_rd[31])
                begin
                    fre_next     = 1'b1;
                    fre_idx_next = idx_reg;
                end
                own_raddr = idx_reg + 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == mtst_pkg::slot_t'(NS - 1))
                begin
                    state_next = ST_IDLE;
                    if (!hit_reg && own_rd == val_reg)
                        cur_next = idx_reg;
                    else if (hit_reg)
                        cur_next = hit_idx_reg;
                    else if (fre_reg || own_rd[31])
                    begin
                        cur_next  = (fre_reg) ? fre_idx_reg : idx_reg;
                        own_we    = 1'b1;
                        own_waddr = cur_next;
                        own_vld_next[cur_next] = 1'b1;
                    end
                    else
                        cur_next = mtst_pkg::slot_t'(NS - 1);
                    down_next[cur_next] = 1'b1;
                end
            end
            ST_RDRPT:
            begin
                pressed_next  = down_reg[mtst_pkg::RPT_IDX];
                pos_hold_next = pos_rd;
                axis_next     = 1'b0;
                state_next    = down_reg[mtst_pkg::RPT_IDX] ? ST_AXIS : ST_OUT;
            end
            ST_AXIS:
            begin
                diff_next   = 33'(raw) - 33'(ilo);
                span_o_next = {1'b0, ohi} - {1'b0, olo};
                den_next    = 17'($signed({ihi[15], ihi}) - $signed({ilo[15], ilo}));
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = 47'($signed(diff_reg)) * 47'($signed(span_o_reg));
                state_next = ST_DIV;
                bit_next   = 6'(DW);
                rem_next   = '0;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // set up magnitude for the divider
                neg_next   = prod_reg[46];
                quo_next   = prod_reg[46] ? DW'(-prod_reg) : DW'(prod_reg);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (bit_reg == 6'd0)
                begin
                    if (axis_reg)
                    begin
                        held_y_next = clamp_v;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        held_x_next = clamp_v;
                        axis_next   = 1'b1;
                        state_next  = ST_AXIS;
                    end
                end
                else
                begin
                    bit_next = bit_reg - 6'd1;
                    if (rem_sh >= {31'd0, den_reg})
                    begin
                        rem_next = rem_sh - {31'd0, den_reg};
                        quo_next = {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[DW-2:0], 1'b0};
                    end
                end
            end
            ST_OUT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            mode_reg    <= 1'b0;
            down_reg    <= '0;
            pos_vld_reg <= '0;
            own_vld_reg <= '0;
            held_x_reg  <= 12'd0;
            held_y_reg  <= 12'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            mode_reg    <= mode_next;
            down_reg    <= down_next;
            pos_vld_reg <= pos_vld_next;
            own_vld_reg <= own_vld_next;
            held_x_reg  <= held_x_next;
            held_y_reg  <= held_y_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg   <= opcode;
            type_reg <= event_type;
            code_reg <= event_code;
            val_reg  <= event_value;
        end
        pos_ra_reg   <= pos_raddr;
        own_ra_reg   <= own_raddr;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        fre_reg      <= fre_next;
        hit_idx_reg  <= hit_idx_next;
        fre_idx_reg  <= fre_idx_next;
        axis_reg     <= axis_next;
        pressed_reg  <= pressed_next;
        pos_hold_reg <= pos_hold_next;
        diff_reg     <= diff_next;
        span_o_reg   <= span_o_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        bit_reg      <= bit_next;
        neg_reg      <= neg_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign touch_pressed = pressed_reg;
    assign point_x       = held_x_reg;
    assign point_y       = held_y_reg;

endmodule
